// ----- rtl/core/gated_hold_time_qualifier_macros.svh -----
// Assertion macros for the gated hold time qualifier.
`ifndef GATED_HOLD_TIME_QUALIFIER_MACROS_SVH
`define GATED_HOLD_TIME_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define GHTQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghtq: same-cycle check failed");
`define GHTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghtq: next-cycle check failed");
`else
`define GHTQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GHTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/ghtq_pkg.sv -----
// Types and constants shared by the gated hold time qualifier files.
`default_nettype none
package ghtq_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_DIG   = TIME_W / DIGIT_W;
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIG);
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned DIV_W     = HOLD_W + PCT_W;

  localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;
  localparam logic [HOLD_W-1:0] TARGET_RESET  = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TARGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_LISTEN  = 1'd1;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_START   = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_CONSUME = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } pct_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/ghtq_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface ghtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic        detection_enabled;
  logic        listening;
  logic        other_sound_busy;
  logic        tone_present;

  modport source (
    output valid, kind, now_ms, detection_enabled, listening, other_sound_busy,
           tone_present,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, detection_enabled, listening, other_sound_busy,
           tone_present,
    output ready
  );
endinterface

interface ghtq_out_if;
  logic        valid;
  logic        ready;
  logic        is_active;
  logic        detected_now;
  logic [15:0] held_ms;
  logic [6:0]  hold_percent;
  logic        unlock_latched;
  logic        unlock_pending;
  logic        unlock_taken;

  modport source (
    output valid, is_active, detected_now, held_ms, hold_percent, unlock_latched,
           unlock_pending, unlock_taken,
    input  ready
  );
  modport sink (
    input  valid, is_active, detected_now, held_ms, hold_percent, unlock_latched,
           unlock_pending, unlock_taken,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/core/ghtq_pct_div.sv -----
// Serial restoring divider that gives floor(held * 100 / target), one quotient bit a cycle.
`default_nettype none
module ghtq_pct_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ghtq_pkg::HOLD_W-1:0]  dividend,
  input  wire logic [ghtq_pkg::HOLD_W-1:0]  divisor,
  output ghtq_pkg::pct_stat_t               stat
);

  localparam int unsigned DW = ghtq_pkg::DIV_W;
  localparam int unsigned QW = ghtq_pkg::PCT_W;
  localparam int unsigned CW = $clog2(QW);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] num_x100;
  logic          fits;

  assign num_x100 = ({7'd0, dividend} << 6) + ({7'd0, dividend} << 5)
                  + ({7'd0, dividend} << 2);
  assign fits = (rem_r >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num_x100;
      den_nxt = {1'b0, divisor, 6'd0};
      q_nxt   = '0;
      cnt_nxt = CW'(QW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = rem_r - den_r;
      end
      q_nxt   = {q_r[QW-2:0], fits};
      den_nxt = den_r >> 1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = q_r;

endmodule
`default_nettype wire

// ----- rtl/core/gated_hold_time_qualifier.sv -----
// Top level of the gated hold time qualifier.
// Every transaction on in_ch (tick, start, stop or unlock consume) yields exactly
// one result transaction on out_ch, taken after the item has been applied. The
// block works on one item at a time: in_ch.ready is high only when it is idle.
// Its work on an item runs in order: the elapsed time, which a 4-bit subtractor
// forms one nibble a cycle over the 32-bit timestamp; the update that applies the
// item; and the hold percentage: a load of the divider, seven quotient bits of a
// restoring divider and the registering of its done flag. The last state loads the
// output register and stalls there while the previous result is still waiting to
// be taken. A finished result waits in the output register while the next item is
// accepted. Configuration writes on cfg_we take effect on the next item and must
// happen while the block is idle.
`default_nettype none
`include "gated_hold_time_qualifier_macros.svh"
module gated_hold_time_qualifier #(
  parameter int unsigned MAX_STEP_MS = 250,
  parameter int unsigned MIN_HOLD_MS = 100
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ghtq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ghtq_pkg::CFG_W-1:0]      cfg_data,
  ghtq_in_if.sink                              in_ch,
  ghtq_out_if.source                           out_ch
);

  localparam int unsigned TW = ghtq_pkg::TIME_W;
  localparam int unsigned HW = ghtq_pkg::HOLD_W;
  localparam int unsigned DG = ghtq_pkg::DIGIT_W;
  localparam int unsigned CW = ghtq_pkg::DIG_CNT_W;
  localparam logic [HW-1:0] MAX_STEP = HW'(MAX_STEP_MS);
  localparam logic [HW-1:0] MIN_HOLD = HW'(MIN_HOLD_MS);

  ghtq_pkg::state_t state_r, state_nxt;

  logic [HW-1:0] hold_target_r;
  logic          req_listen_r;

  logic [1:0]    kind_r;
  logic [TW-1:0] now_r;
  logic          enabled_r, listen_r, busy_r, tone_r;

  logic [TW-1:0] a_sh_r, a_sh_nxt;
  logic [TW-1:0] b_sh_r, b_sh_nxt;
  logic [TW-1:0] diff_sh_r, diff_sh_nxt;
  logic          borrow_r, borrow_nxt;
  logic [CW-1:0] dig_cnt_r, dig_cnt_nxt;
  logic [DG:0]   dig_sum;

  logic          running_r, running_nxt;
  logic          seen_r, seen_nxt;
  logic [TW-1:0] last_tick_r, last_tick_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic          latched_r, latched_nxt;
  logic          pending_r, pending_nxt;
  logic          detected_r, detected_nxt;
  logic          taken_r, taken_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          o_active_r, o_detected_r, o_latched_r, o_pending_r, o_taken_r;
  logic [HW-1:0] o_held_r;
  logic [ghtq_pkg::PCT_W-1:0] o_pct_r, pct_val;

  logic [HW-1:0] target;
  logic [HW-1:0] step;
  logic [HW:0]   sum;
  logic          gate_ok;

  logic          accept, sub_en, upd_en, div_start, out_load;
  ghtq_pkg::pct_stat_t pct_stat;

  assign target  = (hold_target_r < MIN_HOLD) ? MIN_HOLD : hold_target_r;
  assign gate_ok = enabled_r && (!req_listen_r || listen_r) && !busy_r && tone_r;
  assign accept  = in_ch.valid && in_ch.ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ghtq_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = ghtq_pkg::ST_SUB;
      end
      ghtq_pkg::ST_SUB: begin
        if (dig_cnt_r == CW'(ghtq_pkg::NUM_DIG - 1)) state_nxt = ghtq_pkg::ST_UPD;
      end
      ghtq_pkg::ST_UPD:    state_nxt = ghtq_pkg::ST_DIV_GO;
      ghtq_pkg::ST_DIV_GO: state_nxt = ghtq_pkg::ST_DIV_WAIT;
      ghtq_pkg::ST_DIV_WAIT: begin
        if (pct_stat.done) state_nxt = ghtq_pkg::ST_OUT;
      end
      ghtq_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ghtq_pkg::ST_IDLE;
      end
      default: state_nxt = ghtq_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ch.ready = 1'b0;
    sub_en      = 1'b0;
    upd_en      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ghtq_pkg::ST_IDLE:     in_ch.ready = 1'b1;
      ghtq_pkg::ST_SUB:      sub_en = 1'b1;
      ghtq_pkg::ST_UPD:      upd_en = 1'b1;
      ghtq_pkg::ST_DIV_GO:   div_start = 1'b1;
      ghtq_pkg::ST_DIV_WAIT: ;
      ghtq_pkg::ST_OUT:      out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Elapsed time, one nibble a cycle, least significant first.
  assign dig_sum = {1'b0, a_sh_r[DG-1:0]} - {1'b0, b_sh_r[DG-1:0]} - {{DG{1'b0}}, borrow_r};

  always_comb begin
    a_sh_nxt    = a_sh_r;
    b_sh_nxt    = b_sh_r;
    diff_sh_nxt = diff_sh_r;
    borrow_nxt  = borrow_r;
    dig_cnt_nxt = dig_cnt_r;
    if (accept) begin
      a_sh_nxt    = in_ch.now_ms;
      b_sh_nxt    = last_tick_r;
      borrow_nxt  = 1'b0;
      dig_cnt_nxt = '0;
    end else if (sub_en) begin
      a_sh_nxt    = a_sh_r >> DG;
      b_sh_nxt    = b_sh_r >> DG;
      diff_sh_nxt = {dig_sum[DG-1:0], diff_sh_r[TW-1:DG]};
      borrow_nxt  = dig_sum[DG];
      dig_cnt_nxt = dig_cnt_r + 1'b1;
    end
  end

  assign step = (!seen_r || borrow_r) ? '0 :
                (diff_sh_r > TW'(MAX_STEP)) ? MAX_STEP : diff_sh_r[HW-1:0];
  assign sum  = {1'b0, held_r} + {1'b0, step};

  // Item semantics, applied once the elapsed time is known.
  always_comb begin
    running_nxt   = running_r;
    seen_nxt      = seen_r;
    last_tick_nxt = last_tick_r;
    held_nxt      = held_r;
    latched_nxt   = latched_r;
    pending_nxt   = pending_r;
    detected_nxt  = detected_r;
    taken_nxt     = taken_r;
    if (upd_en) begin
      taken_nxt = 1'b0;
      case (ghtq_pkg::kind_t'(kind_r))
        ghtq_pkg::KIND_TICK: begin
          if (!running_r) begin
            detected_nxt = 1'b0;
          end else if (!gate_ok) begin
            held_nxt      = '0;
            pending_nxt   = 1'b0;
            last_tick_nxt = now_r;
            seen_nxt      = 1'b1;
            detected_nxt  = 1'b0;
          end else begin
            detected_nxt  = 1'b1;
            last_tick_nxt = now_r;
            seen_nxt      = 1'b1;
            if (held_r < target) begin
              held_nxt = (sum > {1'b0, target}) ? target : sum[HW-1:0];
            end
            if (!latched_r && (held_nxt >= target)) begin
              latched_nxt = 1'b1;
              pending_nxt = 1'b1;
            end
          end
        end
        ghtq_pkg::KIND_START: begin
          running_nxt   = 1'b1;
          held_nxt      = '0;
          pending_nxt   = 1'b0;
          latched_nxt   = 1'b0;
          last_tick_nxt = now_r;
          seen_nxt      = 1'b1;
        end
        ghtq_pkg::KIND_STOP: begin
          running_nxt = 1'b0;
          held_nxt    = '0;
          pending_nxt = 1'b0;
          latched_nxt = 1'b0;
        end
        ghtq_pkg::KIND_CONSUME: begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            taken_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  ghtq_pct_div u_pct_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (held_r),
    .divisor  (target),
    .stat     (pct_stat)
  );

  assign pct_val = !running_r ? '0 :
                   (held_r >= target) ? ghtq_pkg::PCT_FULL : pct_stat.quot;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ghtq_pkg::ST_IDLE;
      hold_target_r <= ghtq_pkg::TARGET_RESET;
      req_listen_r  <= 1'b0;
      running_r     <= 1'b0;
      seen_r        <= 1'b0;
      last_tick_r   <= '0;
      held_r        <= '0;
      latched_r     <= 1'b0;
      pending_r     <= 1'b0;
      detected_r    <= 1'b0;
      taken_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      dig_cnt_r     <= '0;
      borrow_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      seen_r      <= seen_nxt;
      last_tick_r <= last_tick_nxt;
      held_r      <= held_nxt;
      latched_r   <= latched_nxt;
      pending_r   <= pending_nxt;
      detected_r  <= detected_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      borrow_r    <= borrow_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ghtq_pkg::CFG_HOLD_TARGET: hold_target_r <= cfg_data[HW-1:0];
          ghtq_pkg::CFG_REQ_LISTEN:  req_listen_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
    a_sh_r    <= a_sh_nxt;
    b_sh_r    <= b_sh_nxt;
    diff_sh_r <= diff_sh_nxt;
    if (accept) begin
      kind_r    <= in_ch.kind;
      now_r     <= in_ch.now_ms;
      enabled_r <= in_ch.detection_enabled;
      listen_r  <= in_ch.listening;
      busy_r    <= in_ch.other_sound_busy;
      tone_r    <= in_ch.tone_present;
    end
    if (out_load) begin
      o_active_r   <= running_r;
      o_detected_r <= detected_r;
      o_held_r     <= held_r;
      o_pct_r      <= pct_val;
      o_latched_r  <= latched_r;
      o_pending_r  <= pending_r;
      o_taken_r    <= taken_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_active      = o_active_r;
  assign out_ch.detected_now   = o_detected_r;
  assign out_ch.held_ms        = o_held_r;
  assign out_ch.hold_percent   = o_pct_r;
  assign out_ch.unlock_latched = o_latched_r;
  assign out_ch.unlock_pending = o_pending_r;
  assign out_ch.unlock_taken   = o_taken_r;

  `GHTQ_ASSERT_SAME(a_pending_needs_latch, clk, rst_n, pending_r, latched_r)
  `GHTQ_ASSERT_NEXT(a_accept_starts_sub, clk, rst_n, accept, state_r == ghtq_pkg::ST_SUB)
  `GHTQ_ASSERT_SAME(a_div_done_in_wait, clk, rst_n, pct_stat.done, state_r == ghtq_pkg::ST_DIV_WAIT)
  `GHTQ_ASSERT_SAME(a_pct_in_range, clk, rst_n, out_valid_r, o_pct_r <= ghtq_pkg::PCT_FULL)

endmodule
`default_nettype wire
